@@ rtl/rebp_pkg.sv @@
package rebp_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int BYTE_BITS   = 8;
  localparam int K_BITS      = 4;
  localparam int ONES_BITS   = SYMBOL_BITS;
  localparam int TAIL_BITS   = SYMBOL_BITS + 1;
  localparam int REM_BITS    = 10;

  localparam logic [K_BITS-1:0] MAX_K   = 4'd8;
  localparam logic [K_BITS-1:0] K_RESET = 4'd2;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   end_of_stream;
  } rebp_in_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] code_byte;
    logic                 run_last;
    logic                 stream_done;
  } rebp_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } rebp_cmd_t;

  typedef struct packed {
    logic out_full;
    logic finish;
  } rebp_status_t;

endpackage

@@ rtl/rebp_ctrl.sv @@
module rebp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sym_valid,
  output logic                  sym_ready,
  input  logic                  code_ready,
  input  rebp_pkg::rebp_status_t status,
  output rebp_pkg::rebp_cmd_t    cmd
);
  import rebp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign sym_ready = (state == ST_IDLE);
  assign cmd.load  = sym_valid && sym_ready;
  assign cmd.step  = (state == ST_RUN) && (!status.out_full || code_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && status.finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/rebp_datapath.sv @@
module rebp_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rebp_pkg::K_BITS-1:0] cfg_wdata,
  input  rebp_pkg::rebp_in_t          sym_data,
  input  logic                       code_ready,
  output logic                       code_valid,
  output rebp_pkg::rebp_out_t         code_data,
  input  rebp_pkg::rebp_cmd_t         cmd,
  output rebp_pkg::rebp_status_t      status
);
  import rebp_pkg::*;

  logic [K_BITS-1:0]      rice_k;
  logic [K_BITS-1:0]      k_eff;
  logic [ONES_BITS-1:0]   ones;
  logic [ONES_BITS-1:0]   ones_next;
  logic [TAIL_BITS-1:0]   tail;
  logic [TAIL_BITS-1:0]   tail_next;
  logic [3:0]             tail_cnt;
  logic [3:0]             tail_cnt_next;
  logic [6:0]             pend;
  logic [6:0]             pend_next;
  logic [2:0]             cnt;
  logic [2:0]             cnt_next;
  logic                   eos;
  logic [3:0]             space;
  logic [3:0]             n;
  logic [3:0]             sum;
  logic [BYTE_BITS:0]     ones_mask;
  logic [BYTE_BITS-1:0]   bits;
  logic [BYTE_BITS-1:0]   acc_w;
  logic [BYTE_BITS-1:0]   byte_out;
  logic                   emit;
  logic                   last;
  logic [REM_BITS-1:0]    rem_next;

  assign k_eff = (rice_k > MAX_K) ? MAX_K : rice_k;

  always_comb begin
    space         = 4'd8 - {1'b0, cnt};
    n             = '0;
    bits          = '0;
    ones_next     = ones;
    tail_next     = tail;
    tail_cnt_next = tail_cnt;
    ones_mask     = ~({(BYTE_BITS+1){1'b1}} << n);
    if (ones != '0) begin
      n         = ({4'b0, space} < ones) ? space : ones[3:0];
      ones_mask = ~({(BYTE_BITS+1){1'b1}} << n);
      bits      = ones_mask[BYTE_BITS-1:0];
      ones_next = ones - {4'b0, n};
    end else if (tail_cnt != '0) begin
      n             = (space < tail_cnt) ? space : tail_cnt;
      bits          = BYTE_BITS'(tail >> (4'd9 - n));
      tail_next     = tail << n;
      tail_cnt_next = tail_cnt - n;
    end
    sum   = {1'b0, cnt} + n;
    acc_w = BYTE_BITS'({1'b0, pend} << n) | bits;
    emit      = 1'b0;
    byte_out  = acc_w;
    pend_next = acc_w[6:0];
    cnt_next  = sum[2:0];
    if (sum == 4'd8) begin
      emit      = 1'b1;
      pend_next = '0;
      cnt_next  = '0;
    end else if (n == '0 && eos && cnt != '0) begin
      emit      = 1'b1;
      byte_out  = BYTE_BITS'({1'b0, pend} << (4'd8 - {1'b0, cnt}));
      pend_next = '0;
      cnt_next  = '0;
    end
    rem_next = REM_BITS'(ones_next) + REM_BITS'(tail_cnt_next) + REM_BITS'(cnt_next);
    last     = eos ? (rem_next == '0) : (rem_next < REM_BITS'(BYTE_BITS));
  end

  assign status.out_full = code_valid;
  assign status.finish   = (ones_next == '0) && (tail_cnt_next == '0) &&
                           (!eos || cnt_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rice_k     <= K_RESET;
      pend       <= '0;
      cnt        <= '0;
      ones       <= '0;
      tail_cnt   <= '0;
      code_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        rice_k <= cfg_wdata;
      end
      if (cmd.load) begin
        ones     <= sym_data.symbol >> k_eff;
        tail_cnt <= k_eff + 4'd1;
      end else if (cmd.step) begin
        ones     <= ones_next;
        tail_cnt <= tail_cnt_next;
        pend     <= pend_next;
        cnt      <= cnt_next;
      end
      if (cmd.step && emit) begin
        code_valid <= 1'b1;
      end else if (code_ready) begin
        code_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tail <= {1'b0, BYTE_BITS'(sym_data.symbol << (4'd8 - k_eff))};
      eos  <= sym_data.end_of_stream;
    end else if (cmd.step) begin
      tail <= tail_next;
    end
    if (cmd.step && emit) begin
      code_data.code_byte   <= byte_out;
      code_data.run_last    <= last;
      code_data.stream_done <= last && eos;
    end
  end

endmodule

@@ rtl/rice_encoder_byte_packer.sv @@
// Channel    Direction  Signals                               Moves
// sym        in         sym_valid, sym_ready, sym_data        one symbol and end flag
// code       out        code_valid, code_ready, code_data     one packed byte
// cfg        in         cfg_we, cfg_wdata                     Rice parameter write
//
// A symbol is loaded, then the packer takes one step per cycle while no output byte
// waits or the waiting byte is taken; a step appends up to eight bits but never mixes
// unary and remainder bits, and a stream end that leaves a partial byte adds a pad step.
// Reset is synchronous; it empties the pending bits and sets the parameter to 2.
// A stalled output byte holds the packer; a new symbol is taken once the
// previous one has produced all its bytes, even while the last byte waits.
module rice_encoder_byte_packer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sym_valid,
  output logic                       sym_ready,
  input  rebp_pkg::rebp_in_t          sym_data,
  output logic                       code_valid,
  input  logic                       code_ready,
  output rebp_pkg::rebp_out_t         code_data,
  input  logic                       cfg_we,
  input  logic [rebp_pkg::K_BITS-1:0] cfg_wdata
);
  import rebp_pkg::*;

  rebp_cmd_t    cmd;
  rebp_status_t status;

  rebp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .sym_valid  (sym_valid),
    .sym_ready  (sym_ready),
    .code_ready (code_ready),
    .status     (status),
    .cmd        (cmd)
  );

  rebp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sym_data   (sym_data),
    .code_ready (code_ready),
    .code_valid (code_valid),
    .code_data  (code_data),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

@@ rtl/rebp_checker.sv @@
module rebp_checker (
  input logic                clk,
  input logic                rst,
  input logic                sym_valid,
  input logic                sym_ready,
  input logic                code_valid,
  input logic                code_ready,
  input rebp_pkg::rebp_out_t code_data
);
  import rebp_pkg::*;

  // The final byte of a stream always closes its symbol's run.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> (!code_data.stream_done || code_data.run_last))
    else $error("stream_done without run_last");

  // After a symbol is taken, no further symbol is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sym_valid && sym_ready) |=> !sym_ready)
    else $error("symbol accepted while the previous one is in work");

  // Reset leaves no byte on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !code_valid)
    else $error("output valid right after reset");

  // A byte that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (code_valid && !code_ready) |=> (code_valid && $stable(code_data)))
    else $error("output transaction changed while stalled");

endmodule

bind rice_encoder_byte_packer rebp_checker u_rebp_checker (
  .clk        (clk),
  .rst        (rst),
  .sym_valid  (sym_valid),
  .sym_ready  (sym_ready),
  .code_valid (code_valid),
  .code_ready (code_ready),
  .code_data  (code_data)
);
